// ===== rtl/core/febd_pkg.sv =====
package febd_pkg;

   localparam int COEF_W    = 16;
   localparam int ENERGY_W  = 21;
   localparam int FACTOR_W  = 12;
   localparam int INDEX_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;

   localparam logic signed [ENERGY_W:0] ACC_MAX = (ENERGY_W+1)'(1048575);
   localparam logic signed [ENERGY_W:0] ACC_MIN = -(ENERGY_W+1)'(1048576);

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(256);
   localparam int FRAC_SCALE = 256;

   typedef logic signed [ENERGY_W-1:0] energy_type;

   typedef struct packed {
      logic       vld;
      energy_type energy;
   } frame_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] threshold_factor;
      logic                detect_override;
      logic                clear_after_batch;
   } cfg_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD_FACTOR  = 2'd0,
      CSR_DETECT_OVERRIDE   = 2'd1,
      CSR_CLEAR_AFTER_BATCH = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/core/febd_req_if.sv =====
interface febd_req_if import febd_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] mel_coef;
   logic                     frame_last;

   modport source (output valid, output mel_coef, output frame_last, input ready);
   modport sink (input valid, input mel_coef, input frame_last, output ready);
endinterface

// ===== rtl/core/febd_rsp_if.sv =====
interface febd_rsp_if import febd_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [ENERGY_W-1:0] frame_energy;
   logic                       frame_above;
   logic [INDEX_W-1:0]         frame_index;
   logic                       batch_done;
   logic                       send_batch;

   modport source (output valid, output frame_energy, output frame_above,
                   output frame_index, output batch_done, output send_batch, input ready);
   modport sink (input valid, input frame_energy, input frame_above,
                 input frame_index, input batch_done, input send_batch, output ready);
endinterface

// ===== rtl/core/febd_csr_if.sv =====
interface febd_csr_if import febd_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/febd_accum.sv =====
module febd_accum import febd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   febd_req_if.sink  req,
   input  logic      take,
   output frame_type frame
);

   energy_type             acc_ff, acc_in;
   logic                   vld_ff, vld_in;
   energy_type             energy_ff;
   logic                   fire;
   logic signed [ENERGY_W:0] sum;
   energy_type             sat;

   assign req.ready = !vld_ff || take;
   assign fire      = req.valid && req.ready;

   always_comb begin
      sum = (ENERGY_W+1)'(acc_ff) + (ENERGY_W+1)'(req.mel_coef);
      if (sum > ACC_MAX) begin
         sat = ENERGY_W'(ACC_MAX);
      end else if (sum < ACC_MIN) begin
         sat = ENERGY_W'(ACC_MIN);
      end else begin
         sat = ENERGY_W'(sum);
      end
      acc_in = acc_ff;
      vld_in = vld_ff && !take;
      if (fire) begin
         if (req.frame_last) begin
            acc_in = '0;
            vld_in = 1'b1;
         end else begin
            acc_in = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && req.frame_last) begin
         energy_ff <= sat;
      end
   end

   assign frame.vld    = vld_ff;
   assign frame.energy = energy_ff;

endmodule

// ===== rtl/core/febd_ring.sv =====
module febd_ring import febd_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        update,
   input  energy_type                                  energy,
   output logic signed [ENERGY_W+$clog2(DEPTH)-1:0]    sum
);

   localparam int SUM_W = ENERGY_W + $clog2(DEPTH);
   localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [POS_W-1:0] LAST = POS_W'(DEPTH - 1);

   energy_type                mem [DEPTH];
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      wrap_ff, wrap_in;
   logic                      byp_ff, byp_in;
   energy_type                byp_data_ff;
   energy_type                rd_ff;
   energy_type                old;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;

   always_comb begin
      pos_in  = pos_ff;
      wrap_in = wrap_ff;
      if (update) begin
         if (pos_ff == LAST) begin
            pos_in  = '0;
            wrap_in = 1'b1;
         end else begin
            pos_in = POS_W'(pos_ff + 1'b1);
         end
      end
      byp_in = update && (pos_in == pos_ff);
      if (byp_ff) begin
         old = byp_data_ff;
      end else if (wrap_ff) begin
         old = rd_ff;
      end else begin
         old = '0;
      end
      sum_in = sum_ff;
      if (update) begin
         sum_in = sum_ff + SUM_W'(energy) - SUM_W'(old);
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         mem[pos_ff] <= energy;
      end
      rd_ff       <= mem[pos_in];
      byp_data_ff <= energy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         wrap_ff <= 1'b0;
         byp_ff  <= 1'b0;
         sum_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         wrap_ff <= wrap_in;
         byp_ff  <= byp_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/core/febd_judge.sv =====
module febd_judge import febd_pkg::*; #(
   parameter int FRAMES_PER_BATCH = 20,
   parameter int SHORT_WINDOW     = 4,
   parameter int LONG_WINDOW      = 64
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  cfg_type                                           cfg,
   input  frame_type                                         frame,
   output logic                                              take,
   input  logic signed [ENERGY_W+$clog2(SHORT_WINDOW)-1:0]   short_sum,
   input  logic signed [ENERGY_W+$clog2(LONG_WINDOW)-1:0]    long_sum,
   febd_rsp_if.source                                        rsp
);

   localparam int LSUM_W = ENERGY_W + $clog2(LONG_WINDOW);
   localparam int CMP_W  = ENERGY_W + $clog2(SHORT_WINDOW) + $clog2(LONG_WINDOW)
                           + FACTOR_W + 2;
   localparam int PL_W   = LSUM_W + FACTOR_W + 1;
   localparam int CNT_W  = (FRAMES_PER_BATCH > 1) ? $clog2(FRAMES_PER_BATCH) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAMES_PER_BATCH - 1);
   localparam logic signed [CMP_W-1:0] LONG_SCALE  = CMP_W'(LONG_WINDOW * FRAC_SCALE);
   localparam logic signed [CMP_W-1:0] SHORT_SCALE = CMP_W'(SHORT_WINDOW);

   logic                     c_vld_ff, c_vld_in;
   energy_type               c_energy_ff;
   logic                     d_vld_ff, d_vld_in;
   energy_type               d_energy_ff;
   logic signed [CMP_W-1:0]  p_short_ff, p_short_in;
   logic signed [PL_W-1:0]   p_long_ff, p_long_in;
   logic signed [CMP_W-1:0]  short_ext;
   logic signed [PL_W-1:0]   long_ext;
   logic signed [PL_W-1:0]   factor_ext;
   logic signed [CMP_W-1:0]  rhs;
   logic                     d_ready, out_ready;
   logic                     fire_b, fire_c, fire_d;
   logic                     above, flag_set, done;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     flag_ff, flag_in;
   logic                     out_vld_ff, out_vld_in;
   energy_type               out_energy_ff;
   logic                     out_above_ff;
   logic [INDEX_W-1:0]       out_index_ff;
   logic                     out_done_ff;
   logic                     out_send_ff;

   assign out_ready = !out_vld_ff || rsp.ready;
   assign d_ready   = !d_vld_ff || out_ready;
   assign take      = !c_vld_ff || d_ready;
   assign fire_b    = frame.vld && take;
   assign fire_c    = c_vld_ff && d_ready;
   assign fire_d    = d_vld_ff && out_ready;

   always_comb begin
      short_ext  = CMP_W'(short_sum);
      long_ext   = PL_W'(long_sum);
      factor_ext = PL_W'($signed({1'b0, cfg.threshold_factor}));
      p_short_in = CMP_W'(short_ext * LONG_SCALE);
      p_long_in  = PL_W'(long_ext * factor_ext);
      rhs        = CMP_W'(CMP_W'(p_long_ff) * SHORT_SCALE);
      above      = p_short_ff > rhs;
      flag_set   = flag_ff || above || cfg.detect_override;
      done       = (cnt_ff == CNT_LAST);

      c_vld_in   = fire_b || (c_vld_ff && !d_ready);
      d_vld_in   = fire_c || (d_vld_ff && !out_ready);
      out_vld_in = fire_d || (out_vld_ff && !rsp.ready);

      cnt_in  = cnt_ff;
      flag_in = flag_ff;
      if (fire_d) begin
         if (done) begin
            cnt_in  = '0;
            flag_in = flag_set && !cfg.clear_after_batch;
         end else begin
            cnt_in  = CNT_W'(cnt_ff + 1'b1);
            flag_in = flag_set;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         cnt_ff     <= '0;
         flag_ff    <= 1'b0;
      end else begin
         c_vld_ff   <= c_vld_in;
         d_vld_ff   <= d_vld_in;
         out_vld_ff <= out_vld_in;
         cnt_ff     <= cnt_in;
         flag_ff    <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_b) begin
         c_energy_ff <= frame.energy;
      end
      if (fire_c) begin
         d_energy_ff <= c_energy_ff;
         p_short_ff  <= p_short_in;
         p_long_ff   <= p_long_in;
      end
      if (fire_d) begin
         out_energy_ff <= d_energy_ff;
         out_above_ff  <= above;
         out_index_ff  <= INDEX_W'(cnt_ff);
         out_done_ff   <= done;
         out_send_ff   <= done && flag_set;
      end
   end

   assign rsp.valid        = out_vld_ff;
   assign rsp.frame_energy = out_energy_ff;
   assign rsp.frame_above  = out_above_ff;
   assign rsp.frame_index  = out_index_ff;
   assign rsp.batch_done   = out_done_ff;
   assign rsp.send_batch   = out_send_ff;

endmodule

// ===== rtl/core/frame_energy_burst_detector.sv =====
// Channel   Direction  Payload
// req_port  in         mel_coef (s16), frame_last
// rsp_port  out        frame_energy (s21), frame_above, frame_index (5), batch_done, send_batch
// csr_port  in         index (2), data (12); always ready
//
// One coefficient item is taken every cycle unless a finished frame waits on a stalled judge;
// a frame's result then passes in turn through the ring, product and compare registers.
// Ring reads come from a prefetched memory word, so frames may end on consecutive cycles.
// Synchronous reset clears the accumulator, running sums, ring positions and counters;
// unwritten ring entries read as zero through a wrap flag, so no clearing pass is needed.
// A stalled result holds the pipeline stage by stage; empty stages still take new items.
module frame_energy_burst_detector import febd_pkg::*; #(
   parameter int FRAMES_PER_BATCH = 20,
   parameter int SHORT_WINDOW     = 4,
   parameter int LONG_WINDOW      = 64
) (
   input  logic        clock,
   input  logic        reset,
   febd_req_if.sink    req_port,
   febd_rsp_if.source  rsp_port,
   febd_csr_if.sink    csr_port
);

   localparam int SSUM_W = ENERGY_W + $clog2(SHORT_WINDOW);
   localparam int LSUM_W = ENERGY_W + $clog2(LONG_WINDOW);

   cfg_type                   cfg_ff, cfg_in;
   frame_type                 frame;
   logic                      take;
   logic                      ring_update;
   logic signed [SSUM_W-1:0]  short_sum;
   logic signed [LSUM_W-1:0]  long_sum;

   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            CSR_THRESHOLD_FACTOR: begin
               cfg_in.threshold_factor = csr_port.data;
            end
            CSR_DETECT_OVERRIDE: begin
               cfg_in.detect_override = csr_port.data[0];
            end
            CSR_CLEAR_AFTER_BATCH: begin
               cfg_in.clear_after_batch = csr_port.data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_factor  <= FACTOR_RESET;
         cfg_ff.detect_override   <= 1'b0;
         cfg_ff.clear_after_batch <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign ring_update = frame.vld && take;

   febd_accum u_accum (
      .clock (clock),
      .reset (reset),
      .req   (req_port),
      .take  (take),
      .frame (frame)
   );

   febd_ring #(.DEPTH(SHORT_WINDOW)) u_short_ring (
      .clock  (clock),
      .reset  (reset),
      .update (ring_update),
      .energy (frame.energy),
      .sum    (short_sum)
   );

   febd_ring #(.DEPTH(LONG_WINDOW)) u_long_ring (
      .clock  (clock),
      .reset  (reset),
      .update (ring_update),
      .energy (frame.energy),
      .sum    (long_sum)
   );

   febd_judge #(
      .FRAMES_PER_BATCH (FRAMES_PER_BATCH),
      .SHORT_WINDOW     (SHORT_WINDOW),
      .LONG_WINDOW      (LONG_WINDOW)
   ) u_judge (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .frame     (frame),
      .take      (take),
      .short_sum (short_sum),
      .long_sum  (long_sum),
      .rsp       (rsp_port)
   );

endmodule
